// ----- hdl/csp_pkg.sv -----
// shared types, constants and the arctangent table of the cone surface evaluator
// no dependencies
package csp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    localparam int XW = 34;
    localparam int ZW = 35;

    typedef logic signed [XW-1:0] cord_t;
    typedef logic signed [ZW-1:0] ang_t;

    typedef enum logic [2:0] {
        REG_RADIUS      = 3'd0,
        REG_CONE_HEIGHT = 3'd1,
        REG_THETA_MAX   = 3'd2,
        REG_MATRIX_COL0 = 3'd3,
        REG_MATRIX_COL1 = 3'd4,
        REG_MATRIX_COL2 = 3'd5,
        REG_MATRIX_COL3 = 3'd6
    } cfg_reg_t;

    localparam ang_t  ANG_PI      = 35'sd3373259426;
    localparam ang_t  ANG_HALF_PI = 35'sd1686629713;
    localparam ang_t  ANG_TWO_PI  = 35'sd6746518852;
    localparam cord_t CORDIC_GAIN = 34'sd652032874;

    function automatic ang_t csp_atan(input int idx);
        logic [31:0] t;
        begin
            case (idx)
                0:  t = 32'h3243F6A8;
                1:  t = 32'h1DAC6705;
                2:  t = 32'h0FADBAFC;
                3:  t = 32'h07F56EA6;
                4:  t = 32'h03FEAB76;
                5:  t = 32'h01FFD55B;
                6:  t = 32'h00FFFAAA;
                7:  t = 32'h007FFF55;
                8:  t = 32'h003FFFEA;
                9:  t = 32'h001FFFFD;
                10: t = 32'h000FFFFF;
                11: t = 32'h0007FFFF;
                12: t = 32'h0003FFFF;
                13: t = 32'h0001FFFF;
                14: t = 32'h0000FFFF;
                15: t = 32'h00007FFF;
                16: t = 32'h00003FFF;
                17: t = 32'h00001FFF;
                18: t = 32'h00000FFF;
                19: t = 32'h000007FF;
                20: t = 32'h000003FF;
                21: t = 32'h000001FF;
                22: t = 32'h000000FF;
                23: t = 32'h0000007F;
                default: t = 32'h0;
            endcase
            csp_atan = $signed({3'b000, t});
        end
    endfunction

endpackage

// ----- hdl/cone_surface_point_eval.sv -----
// cone surface point evaluator: angle, cordic, radius scale, affine transform
// depends on csp_pkg and csp_cordic_stage
// a request passes stages 0 and 1, the cordic stages (capped at 24), then stages a to d
// one request per cycle unless held; each stage holds only while its successor is full
// reset clears valid bits and loads register defaults; datapath registers keep no reset
module cone_surface_point_eval #(
    parameter int CORDIC_STAGES = csp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         u_param,
    input  logic [15:0]         v_param,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic [15:0]         s_coord,
    output logic [15:0]         t_coord
);
    import csp_pkg::*;

    localparam int NS   = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int NSTG = NS + 6;
    localparam int SA   = NS + 2;
    localparam int SB   = NS + 3;
    localparam int SC   = NS + 4;
    localparam int SD   = NS + 5;

    typedef struct packed {
        logic [15:0]        u;
        logic [15:0]        v;
        logic signed [32:0] rw;
        logic               flip;
    } side_t;

    // configuration
    logic signed [15:0] radius_reg, height_reg;
    logic [15:0]        tmax_reg;
    logic [47:0]        col_reg [4];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 16'sd256;
            height_reg <= 16'sd256;
            tmax_reg   <= 16'd51472;
            col_reg[0] <= 48'd256;
            col_reg[1] <= 48'd1 << 24;
            col_reg[2] <= 48'd1 << 40;
            col_reg[3] <= 48'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_RADIUS:      radius_reg <= cfg_data[15:0];
                REG_CONE_HEIGHT: height_reg <= cfg_data[15:0];
                REG_THETA_MAX:   tmax_reg   <= cfg_data[15:0];
                REG_MATRIX_COL0: col_reg[0] <= cfg_data;
                REG_MATRIX_COL1: col_reg[1] <= cfg_data;
                REG_MATRIX_COL2: col_reg[2] <= cfg_data;
                REG_MATRIX_COL3: col_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG:0]   en;

    assign en[NSTG] = out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NSTG; gi++)
        begin : g_en
            assign en[gi] = !vld_reg[gi] || en[gi+1];
        end
    endgenerate

    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (en[i])
                    vld_reg[i] <= vld_next[i];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NSTG-1];

    // stage 0: angle and radius scale
    logic [15:0]        s0_u_reg, s0_v_reg;
    logic [32:0]        s0_ang_reg;
    logic signed [32:0] s0_rw_reg;
    logic [16:0]        omv;

    assign omv = 17'h10000 - {1'b0, v_param};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_u_reg   <= u_param;
            s0_v_reg   <= v_param;
            s0_ang_reg <= {32'(u_param) * 32'(tmax_reg), 1'b0};
            s0_rw_reg  <= radius_reg * $signed({1'b0, omv});
        end
    end

    // stage 1: range reduction and quadrant fold
    ang_t  z0, z1, z_fold;
    logic  flip;
    cord_t x_pipe [NS+1];
    cord_t y_pipe [NS+1];
    ang_t  z_pipe [NS+1];
    side_t side_reg [NS+1];

    always_comb
    begin
        z0 = $signed({2'b00, s0_ang_reg});
        z1 = (z0 > ANG_PI) ? z0 - ANG_TWO_PI : z0;
        flip = 1'b0;
        z_fold = z1;
        if (z1 > ANG_HALF_PI)
        begin
            z_fold = z1 - ANG_PI;
            flip = 1'b1;
        end
        else if (z1 < -ANG_HALF_PI)
        begin
            z_fold = z1 + ANG_PI;
            flip = 1'b1;
        end
    end

    cord_t s1_x_reg, s1_y_reg;
    ang_t  s1_z_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_x_reg    <= CORDIC_GAIN;
            s1_y_reg    <= '0;
            s1_z_reg    <= z_fold;
            side_reg[0] <= '{u: s0_u_reg, v: s0_v_reg, rw: s0_rw_reg, flip: flip};
        end
    end

    assign x_pipe[0] = s1_x_reg;
    assign y_pipe[0] = s1_y_reg;
    assign z_pipe[0] = s1_z_reg;

    // cordic stages
    generate
        for (gi = 0; gi < NS; gi++)
        begin : g_cordic
            csp_cordic_stage #(
                .STAGE_IDX(gi)
            ) u_stage (
                .clk   (clk),
                .en    (en[gi+2]),
                .x_in  (x_pipe[gi]),
                .y_in  (y_pipe[gi]),
                .z_in  (z_pipe[gi]),
                .x_out (x_pipe[gi+1]),
                .y_out (y_pipe[gi+1]),
                .z_out (z_pipe[gi+1])
            );

            always_ff @(posedge clk)
            begin
                if (en[gi+2])
                    side_reg[gi+1] <= side_reg[gi];
            end
        end
    endgenerate

    // stage a: scale by radius times one minus v
    cord_t              cos_v, sin_v;
    logic signed [66:0] a_pc_reg, a_ps_reg;
    logic [15:0]        a_u_reg, a_v_reg;

    assign cos_v = side_reg[NS].flip ? -x_pipe[NS] : x_pipe[NS];
    assign sin_v = side_reg[NS].flip ? -y_pipe[NS] : y_pipe[NS];

    always_ff @(posedge clk)
    begin
        if (en[SA])
        begin
            a_pc_reg <= side_reg[NS].rw * cos_v;
            a_ps_reg <= side_reg[NS].rw * sin_v;
            a_u_reg  <= side_reg[NS].u;
            a_v_reg  <= side_reg[NS].v;
        end
    end

    // stage b: round to q.24, object z
    logic signed [66:0] pc_rnd, ps_rnd;
    logic signed [32:0] pz;
    cord_t              b_p_reg [3];
    logic [15:0]        b_u_reg, b_v_reg;

    assign pc_rnd = a_pc_reg + (67'sd1 <<< 29);
    assign ps_rnd = a_ps_reg + (67'sd1 <<< 29);
    assign pz     = $signed({1'b0, a_v_reg}) * height_reg;

    always_ff @(posedge clk)
    begin
        if (en[SB])
        begin
            b_p_reg[0] <= pc_rnd[63:30];
            b_p_reg[1] <= ps_rnd[63:30];
            b_p_reg[2] <= {pz[32], pz};
            b_u_reg    <= a_u_reg;
            b_v_reg    <= a_v_reg;
        end
    end

    // stage c: coefficient products
    logic signed [49:0] c_prod_reg [3][3];
    logic signed [39:0] c_tr_reg [3];
    logic [15:0]        c_u_reg, c_v_reg;

    always_ff @(posedge clk)
    begin
        if (en[SC])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                    c_prod_reg[r][k] <= $signed(col_reg[k][16*r +: 16]) * b_p_reg[k];
                c_tr_reg[r] <= {$signed(col_reg[3][16*r +: 16]), 24'd0};
            end
            c_u_reg <= b_u_reg;
            c_v_reg <= b_v_reg;
        end
    end

    // stage d: sum, round to q16.16, saturate
    logic signed [51:0] acc [3];
    logic signed [35:0] rnd [3];
    logic signed [31:0] sat [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = 52'(c_prod_reg[r][0]) + 52'(c_prod_reg[r][1])
                   + 52'(c_prod_reg[r][2]) + 52'(c_tr_reg[r]) + 52'sd32768;
            rnd[r] = acc[r][51:16];
            if (rnd[r] > 36'sd2147483647)
                sat[r] = 32'sh7FFFFFFF;
            else if (rnd[r] < -36'sd2147483648)
                sat[r] = 32'sh80000000;
            else
                sat[r] = rnd[r][31:0];
        end
    end

    logic signed [31:0] d_pos_reg [3];
    logic [15:0]        d_u_reg, d_v_reg;

    always_ff @(posedge clk)
    begin
        if (en[SD])
        begin
            for (int r = 0; r < 3; r++)
                d_pos_reg[r] <= sat[r];
            d_u_reg <= c_u_reg;
            d_v_reg <= c_v_reg;
        end
    end

    assign pos_x   = d_pos_reg[0];
    assign pos_y   = d_pos_reg[1];
    assign pos_z   = d_pos_reg[2];
    assign s_coord = d_u_reg;
    assign t_coord = d_v_reg;

    // a free output means every stage can advance
    assert property (@(posedge clk) disable iff (!rst_n) out_ready |-> in_ready)
        else $error("pipeline blocked with output ready");

    assert property (@(posedge clk) disable iff (!rst_n) !out_valid |-> in_ready)
        else $error("pipeline blocked with empty output");

    // a held result blocks only when the stage before it is full too
    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready) |-> (out_valid && !out_ready))
        else $error("input stalled without output back pressure");
endmodule

// ----- hdl/csp_cordic_stage.sv -----
// one registered rotation-mode cordic stage
// depends on csp_pkg
module csp_cordic_stage #(
    parameter int STAGE_IDX = 0
) (
    input  logic           clk,
    input  logic           en,
    input  csp_pkg::cord_t x_in,
    input  csp_pkg::cord_t y_in,
    input  csp_pkg::ang_t  z_in,
    output csp_pkg::cord_t x_out,
    output csp_pkg::cord_t y_out,
    output csp_pkg::ang_t  z_out
);
    import csp_pkg::*;

    localparam ang_t ATAN_VAL = csp_atan(STAGE_IDX);

    cord_t x_reg, y_reg, x_next, y_next, xs, ys;
    ang_t  z_reg, z_next;

    always_comb
    begin
        xs = x_in >>> STAGE_IDX;
        ys = y_in >>> STAGE_IDX;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_VAL;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_VAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// ----- dv/cone_surface_point_eval_tb.sv -----
// self-checking testbench for the cone surface point evaluator
// depends on csp_pkg and cone_surface_point_eval; predicts every position in the bench
`timescale 1ns / 1ps

module cone_surface_point_eval_tb;
    import csp_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0] s;
        logic [15:0] t;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] u_param = '0;
    logic [15:0] v_param = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [15:0] s_coord, t_coord;

    logic signed [15:0] m_radius, m_height;
    logic [15:0] m_theta;
    logic [47:0] m_col[4];
    point_t expected_points[$];
    int errors = 0;
    int send_idle = 0;
    int recv_stall = 0;

    localparam longint ATAN_TBL[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};

    cone_surface_point_eval dut (.*);

    always #5 clk = ~clk;

    function automatic longint coef(logic [47:0] col, int r);
        logic signed [15:0] c;
        c = col[16*r +: 16];
        return longint'(c);
    endfunction

    function automatic logic signed [31:0] round_sat(longint q32);
        longint r;
        r = (q32 + 32768) >>> 16;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function automatic point_t surface_point(logic [15:0] u, logic [15:0] v);
        point_t pt;
        longint ang, cx, cy, xs, ys, rw, acc;
        longint p[3];
        bit flip;
        ang = longint'(u) * longint'(m_theta) * 2;
        if (ang > ANG_PI) ang -= ANG_TWO_PI;
        flip = 1'b0;
        if (ang > ANG_HALF_PI) begin ang -= ANG_PI; flip = 1'b1; end
        else if (ang < -ANG_HALF_PI) begin ang += ANG_PI; flip = 1'b1; end
        cx = CORDIC_GAIN;
        cy = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (ang >= 0)
            begin
                cx -= ys; cy += xs; ang -= ATAN_TBL[i];
            end
            else
            begin
                cx += ys; cy -= xs; ang += ATAN_TBL[i];
            end
        end
        if (flip) begin cx = -cx; cy = -cy; end
        rw = longint'(m_radius) * (65536 - longint'(v));
        p[0] = (rw * cx + (64'sd1 <<< 29)) >>> 30;
        p[1] = (rw * cy + (64'sd1 <<< 29)) >>> 30;
        p[2] = longint'(v) * longint'(m_height);
        for (int r = 0; r < 3; r++)
        begin
            acc = coef(m_col[0], r) * p[0] + coef(m_col[1], r) * p[1]
                + coef(m_col[2], r) * p[2] + (coef(m_col[3], r) <<< 24);
            if (r == 0) pt.x = round_sat(acc);
            else if (r == 1) pt.y = round_sat(acc);
            else pt.z = round_sat(acc);
        end
        pt.s = u;
        pt.t = v;
        return pt;
    endfunction

    task automatic send_point(logic [15:0] u, logic [15:0] v);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        u_param <= u;
        v_param <= v;
        expected_points = {expected_points, surface_point(u, v)};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(negedge clk);
        while (n < 40) begin @(negedge clk); n++; end
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_RADIUS: m_radius = value[15:0];
            REG_CONE_HEIGHT: m_height = value[15:0];
            REG_THETA_MAX: m_theta = value[15:0];
            REG_MATRIX_COL0: m_col[0] = value;
            REG_MATRIX_COL1: m_col[1] = value;
            REG_MATRIX_COL2: m_col[2] = value;
            default: m_col[3] = value;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_points(int count);
        for (int i = 0; i < count; i++) send_point(16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        send_point(16'h0000, 16'h0000);
        send_point(16'hFFFF, 16'hFFFF);
        send_point(16'h4000, 16'h0000);
        send_point(16'h8000, 16'h8000);
        send_point(16'hC000, 16'h0001);
        send_point(16'h0001, 16'hFFFE);
        send_point(16'h5555, 16'hAAAA);
        send_point(16'hAAAA, 16'h5555);
        drain();
        // sweep beyond two pi, extremes of radius and height
        write_reg(REG_THETA_MAX, 48'hFFFF);
        write_reg(REG_RADIUS, 48'h7FFF);
        write_reg(REG_CONE_HEIGHT, 48'h8000);
        for (int k = 0; k < 8; k++) send_point(16'(k * 16'h2000 + 16'h1FFF), 16'(k * 8191));
        drain();
        // extreme matrix coefficients on every row
        write_reg(REG_MATRIX_COL0, 48'h7FFF_8000_7FFF);
        write_reg(REG_MATRIX_COL1, 48'h8000_7FFF_7FFF);
        write_reg(REG_MATRIX_COL2, 48'h7FFF_7FFF_8000);
        write_reg(REG_MATRIX_COL3, 48'h8000_7FFF_8000);
        for (int k = 0; k < 6; k++) send_point(16'(k * 10923), 16'h0000);
        drain();
    endtask

    task automatic test_configs();
        write_reg(REG_RADIUS, 48'h8000);
        write_reg(REG_CONE_HEIGHT, 48'h7FFF);
        write_reg(REG_THETA_MAX, 48'h0000);
        random_points(40);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_RADIUS, {32'h0, 16'($urandom)});
            write_reg(REG_CONE_HEIGHT, {32'h0, 16'($urandom)});
            write_reg(REG_THETA_MAX, {32'h0, 16'($urandom_range(51472))});
            for (int c = 0; c < 4; c++)
                write_reg(cfg_reg_t'(REG_MATRIX_COL0 + c), 48'({$urandom, $urandom}));
            random_points(60);
            drain();
        end
        write_reg(REG_RADIUS, 48'h0100);
        write_reg(REG_CONE_HEIGHT, 48'h0100);
        write_reg(REG_THETA_MAX, 48'd51472);
        write_reg(REG_MATRIX_COL0, 48'h0000_0000_0100);
        write_reg(REG_MATRIX_COL1, 48'h0000_0100_0000);
        write_reg(REG_MATRIX_COL2, 48'h0100_0000_0000);
        write_reg(REG_MATRIX_COL3, 48'h0000_0000_0000);
    endtask

    task automatic test_idling();
        int idle_set[4] = '{0, 84, 0, 13};
        int stall_set[4] = '{0, 0, 84, 13};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = idle_set[ph];
            recv_stall = stall_set[ph];
            random_points(400);
            // hold off until the pipeline is empty
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        random_points(50);
        drain();
    endtask

    always @(negedge clk)
        out_ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result x=%0d", pos_x);
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (pos_x !== e.x) begin $error("pos_x exp %0d got %0d", e.x, pos_x); errors++; end
                if (pos_y !== e.y) begin $error("pos_y exp %0d got %0d", e.y, pos_y); errors++; end
                if (pos_z !== e.z) begin $error("pos_z exp %0d got %0d", e.z, pos_z); errors++; end
                if (s_coord !== e.s)
                begin
                    $error("s_coord exp %0d got %0d", e.s, s_coord);
                    errors++;
                end
                if (t_coord !== e.t)
                begin
                    $error("t_coord exp %0d got %0d", e.t, t_coord);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        m_radius = 16'sd256;
        m_height = 16'sd256;
        m_theta = 16'd51472;
        m_col[0] = 48'd256;
        m_col[1] = 48'd1 << 24;
        m_col[2] = 48'd1 << 40;
        m_col[3] = 48'd0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_configs();
        test_idling();
        if (errors == 0 && expected_points.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
hdl/csp_pkg.sv
hdl/csp_cordic_stage.sv
hdl/cone_surface_point_eval.sv
dv/cone_surface_point_eval_tb.sv
